[rtl/double_ended_queue_unit_macros.svh]
// assertion macros used by the deque top level
`ifndef DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define DQ_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define DQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/dq_pkg.sv]
// types and codes of the double-ended queue unit
package dq_pkg;

   localparam logic [1:0] FUNC_PUSH_FRONT = 2'd0;
   localparam logic [1:0] FUNC_PUSH_BACK  = 2'd1;
   localparam logic [1:0] FUNC_POP_FRONT  = 2'd2;
   localparam logic [1:0] FUNC_POP_BACK   = 2'd3;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic [1:0]         func;
      logic signed [31:0] value;
   } dq_req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [4:0]         count;
      logic signed [31:0] front_value;
      logic signed [31:0] back_value;
   } dq_rsp_type;

endpackage

[rtl/dq_ram.sv]
// ring storage: one write port, one registered read port
module dq_ram #(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [31:0]   wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [31:0]   rd_data
);

   logic [31:0] mem [DEPTH];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/double_ended_queue_unit.sv]
// bounded double-ended queue of signed 32-bit values, top level
//
//   channel   handshake           payload       direction
//   request   start / busy        req_data      in
//   response  rsp_strobe          rsp_data      out
//
// one response per transaction, on the cycle right after acceptance
// pushes, rejected operations and pops that leave at most one entry keep the block idle
// pops that leave two or more entries pass through a read-back state: the new end value is read
//   from the ring memory, whose read port is registered (busy high)
// reset is synchronous: queue empties, head returns to slot zero, no strobe
// the receiver cannot stall; rsp_strobe lasts exactly one cycle
module double_ended_queue_unit #(
   parameter int DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  dq_pkg::dq_req_type req_data,
   output logic               rsp_strobe,
   output dq_pkg::dq_rsp_type rsp_data
);
   import dq_pkg::*;
`include "double_ended_queue_unit_macros.svh"

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = AW + 1;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_FIX  = 1'b1;

   // control state
   logic          state_ff, state_in;
   logic          rsp_strobe_ff, rsp_strobe_in;
   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;
   // payload state: cached end values, response status
   logic          fix_front_ff, fix_front_in;
   logic [31:0]   front_ff, front_in;
   logic [31:0]   back_ff, back_in;
   logic [1:0]    status_ff, status_in;

   // memory port
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_addr;
   logic [31:0]   rd_data;

   logic          accept;
   logic          full;
   logic          empty;
   logic [AW-1:0] head_dec;
   logic [AW-1:0] head_inc;
   logic [CW-1:0] count_m2;
   logic [31:0]   front_out;
   logic [31:0]   back_out;

   // (a + b) mod DEPTH for a < DEPTH, b <= DEPTH
   function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] a, input logic [CW-1:0] b);
      logic [SW-1:0] s;
      s = {1'b0, a} + SW'(b);
      if (s >= SW'(DEPTH)) begin
         s = s - SW'(DEPTH);
      end
      return s[AW-1:0];
   endfunction

   dq_ram #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_data.value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // a new transaction waits while an end value is still being read back
   assign busy   = (state_ff == ST_FIX);
   assign accept = start && !busy;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign head_dec = (head_ff == '0) ? AW'(DEPTH - 1) : head_ff - AW'(1);
   assign head_inc = (head_ff == AW'(DEPTH - 1)) ? '0 : head_ff + AW'(1);
   assign count_m2 = count_ff - CW'(2);

   always_comb begin
      state_in      = ST_IDLE;
      rsp_strobe_in = accept;
      head_in       = head_ff;
      count_in      = count_ff;
      fix_front_in  = fix_front_ff;
      front_in      = front_ff;
      back_in       = back_ff;
      status_in     = status_ff;
      wr_en         = 1'b0;
      wr_addr       = ring_add(head_ff, count_ff);
      rd_addr       = head_inc;

      if (state_ff == ST_FIX) begin
         // memory data for the new end arrives this cycle
         if (fix_front_ff) begin
            front_in = rd_data;
         end else begin
            back_in = rd_data;
         end
      end else if (accept) begin
         status_in = STATUS_OK;
         case (req_data.func)
            FUNC_PUSH_FRONT: begin
               if (full) begin
                  status_in = STATUS_FULL;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = head_dec;
                  head_in  = head_dec;
                  count_in = count_ff + CW'(1);
                  front_in = req_data.value;
                  if (empty) begin
                     back_in = req_data.value;
                  end
               end
            end
            FUNC_PUSH_BACK: begin
               if (full) begin
                  status_in = STATUS_FULL;
               end else begin
                  wr_en    = 1'b1;
                  count_in = count_ff + CW'(1);
                  back_in  = req_data.value;
                  if (empty) begin
                     front_in = req_data.value;
                  end
               end
            end
            FUNC_POP_FRONT: begin
               if (empty) begin
                  status_in = STATUS_EMPTY;
               end else begin
                  head_in  = head_inc;
                  count_in = count_ff - CW'(1);
                  rd_addr  = head_inc;
                  if (count_ff == CW'(2)) begin
                     front_in = back_ff;
                  end else if (count_ff > CW'(2)) begin
                     fix_front_in = 1'b1;
                     state_in     = ST_FIX;
                  end
               end
            end
            FUNC_POP_BACK: begin
               if (empty) begin
                  status_in = STATUS_EMPTY;
               end else begin
                  count_in = count_ff - CW'(1);
                  rd_addr  = ring_add(head_ff, count_m2);
                  if (count_ff == CW'(2)) begin
                     back_in = front_ff;
                  end else if (count_ff > CW'(2)) begin
                     fix_front_in = 1'b0;
                     state_in     = ST_FIX;
                  end
               end
            end
            default: begin
               status_in = STATUS_OK;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_strobe_ff <= 1'b0;
         head_ff       <= '0;
         count_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
         head_ff       <= head_in;
         count_ff      <= count_in;
      end
      fix_front_ff <= fix_front_in;
      front_ff     <= front_in;
      back_ff      <= back_in;
      status_ff    <= status_in;
   end

   // during the read-back cycle the fresh end value bypasses its cache register
   assign front_out = (busy && fix_front_ff)  ? rd_data : front_ff;
   assign back_out  = (busy && !fix_front_ff) ? rd_data : back_ff;

   assign rsp_strobe           = rsp_strobe_ff;
   assign rsp_data.status      = status_ff;
   assign rsp_data.count       = 5'(count_ff);
   assign rsp_data.front_value = empty ? '0 : $signed(front_out);
   assign rsp_data.back_value  = empty ? '0 : $signed(back_out);

   // every accepted transaction answers on the next cycle
   `DQ_ASSERT_NEXT(a_rsp_follows, clock, reset, accept, rsp_strobe, "missing response")
   // a read-back cycle is always a response cycle
   `DQ_ASSERT_IMPL(a_fix_has_rsp, clock, reset, busy, rsp_strobe, "read-back without response")
   // read-back lasts a single cycle
   `DQ_ASSERT_NEXT(a_fix_one_cycle, clock, reset, busy, !busy, "read-back too long")
   // occupancy stays bounded
   `DQ_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(DEPTH), "count overflow")
   // an accepted push on a non-full queue grows it by one
   `DQ_ASSERT_NEXT(a_push_grows, clock, reset,
      accept && !full && (req_data.func == FUNC_PUSH_FRONT || req_data.func == FUNC_PUSH_BACK),
      count_ff == $past(count_ff) + CW'(1), "push did not grow count")

endmodule

[verif/double_ended_queue_unit_tb.sv]
// testbench for the double-ended queue unit: directed table, then biased random traffic
module double_ended_queue_unit_tb;
   import dq_pkg::*;

   localparam int RING_DEPTH   = 16;
   localparam int RANDOM_ITEMS = 700;
   localparam int LONG_GAP     = 40;

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   dq_req_type req_data;
   logic       rsp_strobe;
   dq_rsp_type rsp_data;

   double_ended_queue_unit #(
      .DEPTH(RING_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data(rsp_data)
   );

   // mirror of the ring contents, front position and fill level
   logic signed [31:0] mirror_slots [RING_DEPTH];
   int                 mirror_head;
   int                 mirror_fill;

   // queue-end snapshots still owed by the block, oldest first
   dq_rsp_type rsp_snapshots [$];
   int         mismatches;

   // one row of the directed table; typed rows carry a hand-written snapshot
   typedef struct {
      dq_req_type req;
      bit         typed;
      dq_rsp_type want;
   } stim_row_type;

   stim_row_type directed_rows [$];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #2_000_000;
      $display("status: fail");
      $finish;
   end

   // applies one operation to the mirror and returns the snapshot it leaves
   function automatic dq_rsp_type apply_deque_op(dq_req_type req);
      dq_rsp_type snap;
      snap = '0;
      snap.status = STATUS_OK;
      if (req.func == FUNC_PUSH_FRONT || req.func == FUNC_PUSH_BACK) begin
         if (mirror_fill == RING_DEPTH) begin
            // push on full is rejected, ring untouched
            snap.status = STATUS_FULL;
         end else if (req.func == FUNC_PUSH_FRONT) begin
            mirror_head = (mirror_head + RING_DEPTH - 1) % RING_DEPTH;
            mirror_slots[mirror_head] = req.value;
            mirror_fill++;
         end else begin
            mirror_slots[(mirror_head + mirror_fill) % RING_DEPTH] = req.value;
            mirror_fill++;
         end
      end else begin
         if (mirror_fill == 0) begin
            // pop on empty is rejected
            snap.status = STATUS_EMPTY;
         end else begin
            if (req.func == FUNC_POP_FRONT)
               mirror_head = (mirror_head + 1) % RING_DEPTH;
            mirror_fill--;
         end
      end
      snap.count = mirror_fill[4:0];
      if (mirror_fill != 0) begin
         snap.front_value = mirror_slots[mirror_head];
         snap.back_value  = mirror_slots[(mirror_head + mirror_fill - 1) % RING_DEPTH];
      end
      return snap;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
      mismatches++;
   endtask

   // extremes and special patterns show up often, plain random otherwise
   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(0, 7))
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2: return 32'h0000_0000;
         3: return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   task automatic add_row(logic [1:0] func, logic signed [31:0] value, bit typed,
                          logic [1:0] status, logic [4:0] count,
                          logic signed [31:0] front, logic signed [31:0] back);
      stim_row_type row;
      row.req.func         = func;
      row.req.value        = value;
      row.typed            = typed;
      row.want.status      = status;
      row.want.count       = count;
      row.want.front_value = front;
      row.want.back_value  = back;
      directed_rows.insert(directed_rows.size(), row);
   endtask

   // presents one transaction and holds it until the block takes it
   task automatic send_item(dq_req_type req, bit typed, dq_rsp_type want);
      dq_rsp_type predicted;
      start    <= 1'b1;
      req_data <= req;
      do @(posedge clock); while (busy !== 1'b0);
      predicted = apply_deque_op(req);
      rsp_snapshots.insert(rsp_snapshots.size(), typed ? want : predicted);
   endtask

   // random idle time between transactions, mostly short, now and then long
   task automatic idle_gap(bit no_idle);
      int pick;
      int cycles;
      pick   = $urandom_range(0, 99);
      cycles = 0;
      if (!no_idle) begin
         if (pick >= 90)
            cycles = $urandom_range(4, LONG_GAP);
         else if (pick >= 55)
            cycles = $urandom_range(1, 3);
      end
      if (cycles > 0) begin
         start           <= 1'b0;
         req_data.func   <= 2'($urandom);
         req_data.value  <= pick_value();
         repeat (cycles) @(posedge clock);
      end
   endtask

   // hold the request side off until every owed snapshot has come back
   task automatic drain_block();
      start <= 1'b0;
      @(posedge clock);
      while (rsp_snapshots.size() != 0) @(posedge clock);
   endtask

   // response side: the block cannot be stalled, so every strobe is taken
   always @(posedge clock) begin
      dq_rsp_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (rsp_snapshots.size() == 0) begin
            report_mismatch("unexpected response", 32'(rsp_data.status), 32'd0);
         end else begin
            want = rsp_snapshots[0];
            rsp_snapshots.delete(0);
            if (rsp_data.status !== want.status)
               report_mismatch("status", 32'(rsp_data.status), 32'(want.status));
            if (rsp_data.count !== want.count)
               report_mismatch("count", 32'(rsp_data.count), 32'(want.count));
            if (rsp_data.front_value !== want.front_value)
               report_mismatch("front_value", rsp_data.front_value, want.front_value);
            if (rsp_data.back_value !== want.back_value)
               report_mismatch("back_value", rsp_data.back_value, want.back_value);
         end
      end
   end

   // stimulus and end of run
   initial begin
      dq_req_type req;
      dq_rsp_type none;
      int         push_pct;
      bit         no_idle;

      none        = '0;
      mismatches  = 0;
      mirror_head = 0;
      mirror_fill = 0;
      foreach (mirror_slots[i]) mirror_slots[i] = '0;

      reset    <= 1'b1;
      start    <= 1'b0;
      req_data <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // empty after reset, then the extremes through both ends
      add_row(FUNC_POP_FRONT, 32'h1234_5678, 1, STATUS_EMPTY, 5'd0, 0, 0);
      add_row(FUNC_POP_BACK, 32'hffff_ffff, 1, STATUS_EMPTY, 5'd0, 0, 0);
      add_row(FUNC_PUSH_FRONT, 32'h7fff_ffff, 1, STATUS_OK, 5'd1,
              32'h7fff_ffff, 32'h7fff_ffff);
      add_row(FUNC_PUSH_BACK, 32'h8000_0000, 1, STATUS_OK, 5'd2,
              32'h7fff_ffff, 32'h8000_0000);
      add_row(FUNC_PUSH_FRONT, 32'hffff_ffff, 1, STATUS_OK, 5'd3,
              32'hffff_ffff, 32'h8000_0000);
      add_row(FUNC_POP_BACK, 32'h0, 1, STATUS_OK, 5'd2, 32'hffff_ffff, 32'h7fff_ffff);
      add_row(FUNC_POP_FRONT, 32'h0, 1, STATUS_OK, 5'd1, 32'h7fff_ffff, 32'h7fff_ffff);
      // pop that leaves the queue empty
      add_row(FUNC_POP_FRONT, 32'h0, 1, STATUS_OK, 5'd0, 0, 0);
      // fill from both ends so the ring wraps, then push on full at each end
      for (int i = 0; i < RING_DEPTH; i++)
         add_row((i % 2) ? FUNC_PUSH_BACK : FUNC_PUSH_FRONT, pick_value(), 0,
                 STATUS_OK, 5'd0, 0, 0);
      add_row(FUNC_PUSH_BACK, 32'h5555_5555, 0, STATUS_OK, 5'd0, 0, 0);
      add_row(FUNC_PUSH_FRONT, 32'haaaa_aaaa, 0, STATUS_OK, 5'd0, 0, 0);

      foreach (directed_rows[i]) begin
         send_item(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
         idle_gap(1'b0);
      end

      // let the directed part settle before the random traffic
      drain_block();

      push_pct = 50;
      no_idle  = 1'b0;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         // every block of transactions leans toward filling, draining or neither
         if (i % 50 == 0) begin
            case ($urandom_range(0, 2))
               0: push_pct = 15;
               1: push_pct = 50;
               default: push_pct = 85;
            endcase
            no_idle = ($urandom_range(0, 3) == 0);
         end
         if (i == RANDOM_ITEMS / 2)
            drain_block();
         if ($urandom_range(0, 99) < push_pct)
            req.func = $urandom_range(0, 1) ? FUNC_PUSH_BACK : FUNC_PUSH_FRONT;
         else
            req.func = $urandom_range(0, 1) ? FUNC_POP_BACK : FUNC_POP_FRONT;
         req.value = pick_value();
         send_item(req, 1'b0, none);
         idle_gap(no_idle);
      end

      // wait for the last responses, then a few quiet cycles
      start <= 1'b0;
      @(posedge clock);
      while (rsp_snapshots.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
